/* rtl/core/lnsf_pkg.sv */
// Shared constants and control/status types for the LCD nibble chain framer.
package lnsf_pkg;

    localparam int MAX_CHAIN = 8;
    localparam int POS_W     = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
    localparam int CFG_W     = 4;
    localparam int SEL_W     = 3;
    localparam int VAL_W     = 8;
    localparam int IMG_W     = 6;
    localparam int BYTE_W    = 8;
    localparam int FRAME_W   = 2;

    localparam logic [CFG_W-1:0]   CHAIN_LEN_RESET = 4'd8;
    localparam logic [FRAME_W-1:0] FRAME_FIRST     = 2'd0;
    localparam logic [FRAME_W-1:0] FRAME_FINAL     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               capture;
        logic               load;
        logic               wr_en;
        logic [FRAME_W-1:0] wr_frame;
        logic [POS_W-1:0]   pos;
        logic [FRAME_W-1:0] frame;
        logic               last;
    } lnsf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [POS_W-1:0] len_m1;
        logic             out_free;
    } lnsf_sts_t;

endpackage

/* rtl/core/lnsf_ctrl.sv */
// Sequencer that walks frames and chain positions for each accepted item.
module lnsf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lnsf_pkg::lnsf_sts_t sts,
    output lnsf_pkg::lnsf_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    logic [lnsf_pkg::FRAME_W-1:0]  frame_reg, frame_next;
    logic [lnsf_pkg::POS_W-1:0]    pos_reg, pos_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        frame_next   = frame_reg;
        pos_next     = pos_reg;
        cmd.capture  = 1'b0;
        cmd.load     = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.wr_frame = lnsf_pkg::FRAME_FIRST;
        cmd.pos      = pos_reg;
        cmd.frame    = frame_reg;
        cmd.last     = (pos_reg == '0) && (frame_reg == lnsf_pkg::FRAME_FINAL);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Frame 0 image entry is written as the item is taken.
                    cmd.capture = 1'b1;
                    cmd.wr_en   = 1'b1;
                    state_next  = ST_EMIT;
                    frame_next  = lnsf_pkg::FRAME_FIRST;
                    pos_next    = sts.len_m1;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load = 1'b1;
                    if (pos_reg == '0)
                    begin
                        if (frame_reg == lnsf_pkg::FRAME_FINAL)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // Update the image for the next frame before its first read.
                            cmd.wr_en    = 1'b1;
                            cmd.wr_frame = frame_reg + 2'd1;
                            frame_next   = frame_reg + 2'd1;
                            pos_next     = sts.len_m1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            frame_reg <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frame_reg <= frame_next;
            pos_reg   <= pos_next;
        end
    end

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("controller did not return to idle after final byte");

    a_capture_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (state_reg == ST_EMIT && frame_reg == lnsf_pkg::FRAME_FIRST
                         && pos_reg == $past(sts.len_m1)))
        else $error("walk did not start at top of chain in frame 0");

    a_pos_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= sts.len_m1))
        else $error("position beyond effective chain length");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> sts.out_free)
        else $error("output loaded while still occupied");

endmodule

/* rtl/core/lnsf_datapath.sv */
// Chain image store, configuration register and output register.
module lnsf_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [lnsf_pkg::CFG_W-1:0]    cfg_data,
    input  logic [lnsf_pkg::SEL_W-1:0]    in_sel,
    input  logic                          in_rs,
    input  logic [lnsf_pkg::VAL_W-1:0]    in_val,
    input  lnsf_pkg::lnsf_cmd_t           cmd,
    output lnsf_pkg::lnsf_sts_t           sts,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [lnsf_pkg::BYTE_W-1:0]   out_byte,
    output logic [lnsf_pkg::FRAME_W-1:0]  out_frame,
    output logic                          out_frame_end,
    output logic                          out_last
);

    logic [lnsf_pkg::CFG_W-1:0]   chain_len_reg;
    logic [lnsf_pkg::CFG_W-1:0]   len_dec;
    logic [lnsf_pkg::SEL_W-1:0]   sel_reg;
    logic                         rs_reg;
    logic [lnsf_pkg::VAL_W-1:0]   val_reg;
    logic [lnsf_pkg::IMG_W-1:0]   image_reg [lnsf_pkg::MAX_CHAIN];

    logic [lnsf_pkg::SEL_W-1:0]   wr_sel;
    logic                         wr_rs;
    logic [lnsf_pkg::VAL_W-1:0]   wr_val;
    logic [3:0]                   wr_nib;
    logic [lnsf_pkg::IMG_W-1:0]   wr_entry;

    logic                         out_valid_reg;
    logic [lnsf_pkg::IMG_W-1:0]   out_img_reg;
    logic [lnsf_pkg::FRAME_W-1:0] out_frame_reg;
    logic                         out_frame_end_reg;
    logic                         out_last_reg;

    // Zero means one display; anything past the store saturates.
    assign len_dec = chain_len_reg - {{(lnsf_pkg::CFG_W-1){1'b0}}, 1'b1};
    always_comb
    begin
        sts.out_free = !out_valid_reg || out_ready;
        priority if (chain_len_reg == '0)
            sts.len_m1 = '0;
        else if (int'(chain_len_reg) > lnsf_pkg::MAX_CHAIN)
            sts.len_m1 = lnsf_pkg::POS_W'(lnsf_pkg::MAX_CHAIN - 1);
        else
            sts.len_m1 = len_dec[lnsf_pkg::POS_W-1:0];
    end

    assign wr_sel   = cmd.capture ? in_sel : sel_reg;
    assign wr_rs    = cmd.capture ? in_rs  : rs_reg;
    assign wr_val   = cmd.capture ? in_val : val_reg;
    assign wr_nib   = cmd.wr_frame[1] ? wr_val[3:0] : wr_val[7:4];
    assign wr_entry = {wr_rs, !cmd.wr_frame[0], wr_nib};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_len_reg <= lnsf_pkg::CHAIN_LEN_RESET;
            for (int i = 0; i < lnsf_pkg::MAX_CHAIN; i++)
            begin
                image_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                chain_len_reg <= cfg_data;
            end
            if (cmd.wr_en && (int'(wr_sel) < lnsf_pkg::MAX_CHAIN))
            begin
                image_reg[lnsf_pkg::POS_W'(wr_sel)] <= wr_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sel_reg <= in_sel;
            rs_reg  <= in_rs;
            val_reg <= in_val;
        end
        if (cmd.load)
        begin
            out_img_reg       <= image_reg[cmd.pos];
            out_frame_reg     <= cmd.frame;
            out_frame_end_reg <= (cmd.pos == '0);
            out_last_reg      <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = {{(lnsf_pkg::BYTE_W-lnsf_pkg::IMG_W){1'b0}}, out_img_reg};
    assign out_frame     = out_frame_reg;
    assign out_frame_end = out_frame_end_reg;
    assign out_last      = out_last_reg;

    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_frame_end_reg
                                             && out_frame_reg == lnsf_pkg::FRAME_FINAL))
        else $error("final byte is not the end of the last frame");

    a_held_until_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_img_reg)))
        else $error("pending output byte changed before it was taken");

endmodule

/* rtl/core/lcd_nibble_shift_chain_framer_unit.sv */
// Top level: HD44780 4-bit nibble framer for a chain of shift registers.
// Each item produces 4*L bytes (L = effective chain length, 1..8), one per cycle
// while the output is taken; the first byte enters the output register after the
// sequencer enters its emit state. A new item waits until the frame/position walk ends.
// Reset (rst_n, asynchronous, active low) clears the chain image to zeros,
// sets the chain length to 8 and empties the output register.
module lcd_nibble_shift_chain_framer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data,        // chain_length
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [2:0] display_select, [10:3] value, rest zero
    input  logic        s_axis_tuser,    // [0] reg_select
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] shift_byte
    output logic [2:0]  m_axis_tuser,    // [1:0] frame_index, [2] frame_end
    output logic        m_axis_tlast     // last
);

    lnsf_pkg::lnsf_cmd_t cmd;
    lnsf_pkg::lnsf_sts_t sts;
    logic                in_ready;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = in_ready;

    lnsf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lnsf_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .in_sel        (s_axis_tdata[2:0]),
        .in_rs         (s_axis_tuser),
        .in_val        (s_axis_tdata[10:3]),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_byte      (m_axis_tdata),
        .out_frame     (m_axis_tuser[1:0]),
        .out_frame_end (m_axis_tuser[2]),
        .out_last      (m_axis_tlast)
    );

endmodule
